/* rtl/biq_pkg.sv */
// Shared types, constants and saturation helpers for the biquad IIR filter.
package biq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 19;
    localparam int STATE_W    = 36;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = COEF_W + STATE_W;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_FEED0 = 3'd0,
        REG_FEED1 = 3'd1,
        REG_FEED2 = 3'd2,
        REG_BACK1 = 3'd3,
        REG_BACK2 = 3'd4
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_FILTER = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Y,
        ST_Z1SUM,
        ST_Z1,
        ST_Z2PRE,
        ST_Z2,
        ST_CLEAR
    } state_t;

    typedef enum logic [1:0] {
        MUL_SAMPLE_IN,
        MUL_X,
        MUL_Y
    } mul_src_t;

    typedef enum logic [0:0] {
        ADD_A_PROD,
        ADD_A_ACC
    } add_a_t;

    typedef enum logic [1:0] {
        ADD_B_Z1,
        ADD_B_Z2,
        ADD_B_ZERO,
        ADD_B_PROD
    } add_b_t;

    typedef struct packed {
        reg_idx_t coef_sel;
        mul_src_t mul_src;
        logic     shift_en;
        logic     prod_we;
        add_a_t   add_a;
        add_b_t   add_b;
        logic     add_sub;
        logic     y_we;
        logic     acc_we;
        logic     z1_we;
        logic     z2_we;
        logic     out_we;
        logic     clear;
    } ctrl_t;

    // Saturate a full-width product to the state range.
    function automatic logic signed [STATE_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-STATE_W:0] top;
        top = p[PROD_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            return p[STATE_W-1:0];
        end else if (p[PROD_W-1]) begin
            return STATE_MIN;
        end else begin
            return STATE_MAX;
        end
    endfunction

    // Saturating add or subtract in the state range.
    function automatic logic signed [STATE_W-1:0] sat_sum(
        input logic signed [STATE_W-1:0] a,
        input logic signed [STATE_W-1:0] b,
        input logic                      sub
    );
        logic signed [STATE_W:0] s;
        if (sub) begin
            s = {a[STATE_W-1], a} - {b[STATE_W-1], b};
        end else begin
            s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
        end
        if (s[STATE_W] != s[STATE_W-1]) begin
            return s[STATE_W] ? STATE_MIN : STATE_MAX;
        end else begin
            return s[STATE_W-1:0];
        end
    endfunction

    // Floor the Q.16 value to an integer and saturate to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [STATE_W-1:0] y);
        logic [STATE_W-FRAC_W-SAMPLE_W:0] top;
        top = y[STATE_W-1:FRAC_W+SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return y[FRAC_W+SAMPLE_W-1:FRAC_W];
        end else if (y[STATE_W-1]) begin
            return SAMPLE_MIN;
        end else begin
            return SAMPLE_MAX;
        end
    endfunction

endpackage

/* rtl/biquad_iir_filter.sv */
// Biquad IIR filter in transposed direct form II with a shared multiplier and adder.
// A filter item holds the sequencer from the accept cycle through its last step. The
// first product is formed in the accept cycle. The five steps after it share one
// 19 x 36 signed multiplier and one saturating adder, forming the other four products
// and all five sums. The result is registered out of the last step. A clear item
// passes through the clear step, whose result is registered. s_ready is high only while
// the sequencer is idle. A finished result waits in the output register, and the
// sequencer holds in its last step until that register is free, so a stalled result
// delays the next item by the length of the stall. Coefficients are Q3.16 at byte
// addresses 0, 4, 8, 12 and 16 and reset to zero; the delay state resets to zero.
module biquad_iir_filter
    import biq_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic signed [SAMPLE_W-1:0]   s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SAMPLE_W-1:0]   m_filtered
);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic signed [COEF_W-1:0]   feed0_reg, feed1_reg, feed2_reg, back1_reg, back2_reg;
    logic signed [STATE_W-1:0]  z1_reg, z2_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [STATE_W-1:0]  y_reg, acc_reg, prod_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;

    logic                       cfg_we;
    reg_idx_t                   cfg_idx;
    logic signed [COEF_W-1:0]   rd_coef;
    logic                       in_accept;
    logic                       out_free;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_sample;
    logic signed [STATE_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [PROD_W-1:0]   prod_scaled;
    logic signed [STATE_W-1:0]  add_a_val, add_b_val, sum_val;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_FEED0: rd_coef = feed0_reg;
            REG_FEED1: rd_coef = feed1_reg;
            REG_FEED2: rd_coef = feed2_reg;
            REG_BACK1: rd_coef = back1_reg;
            REG_BACK2: rd_coef = back2_reg;
            default:   rd_coef = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feed0_reg <= '0;
            feed1_reg <= '0;
            feed2_reg <= '0;
            back1_reg <= '0;
            back2_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_FEED0: feed0_reg <= pwdata[COEF_W-1:0];
                REG_FEED1: feed1_reg <= pwdata[COEF_W-1:0];
                REG_FEED2: feed2_reg <= pwdata[COEF_W-1:0];
                REG_BACK1: back1_reg <= pwdata[COEF_W-1:0];
                REG_BACK2: back2_reg <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign m_filtered = filtered_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_command == CMD_CLEAR) ? ST_CLEAR : ST_Y;
                end
            end
            ST_Y:     state_next = ST_Z1SUM;
            ST_Z1SUM: state_next = ST_Z1;
            ST_Z1:    state_next = ST_Z2PRE;
            ST_Z2PRE: state_next = ST_Z2;
            ST_Z2, ST_CLEAR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl          = '0;
        ctrl.coef_sel = REG_FEED0;
        ctrl.mul_src  = MUL_X;
        ctrl.add_a    = ADD_A_PROD;
        ctrl.add_b    = ADD_B_ZERO;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.mul_src = MUL_SAMPLE_IN;
                ctrl.prod_we = in_accept && (s_command == CMD_FILTER);
            end
            ST_Y: begin
                ctrl.add_b    = ADD_B_Z1;
                ctrl.y_we     = 1'b1;
                ctrl.coef_sel = REG_FEED1;
                ctrl.prod_we  = 1'b1;
            end
            ST_Z1SUM: begin
                ctrl.add_b    = ADD_B_Z2;
                ctrl.acc_we   = 1'b1;
                ctrl.coef_sel = REG_BACK1;
                ctrl.mul_src  = MUL_Y;
                ctrl.shift_en = 1'b1;
                ctrl.prod_we  = 1'b1;
            end
            ST_Z1: begin
                ctrl.add_a    = ADD_A_ACC;
                ctrl.add_b    = ADD_B_PROD;
                ctrl.add_sub  = 1'b1;
                ctrl.z1_we    = 1'b1;
                ctrl.coef_sel = REG_FEED2;
                ctrl.prod_we  = 1'b1;
            end
            ST_Z2PRE: begin
                ctrl.acc_we   = 1'b1;
                ctrl.coef_sel = REG_BACK2;
                ctrl.mul_src  = MUL_Y;
                ctrl.shift_en = 1'b1;
                ctrl.prod_we  = 1'b1;
            end
            ST_Z2: begin
                ctrl.add_a   = ADD_A_ACC;
                ctrl.add_b   = ADD_B_PROD;
                ctrl.add_sub = 1'b1;
                ctrl.z2_we   = out_free;
                ctrl.out_we  = out_free;
            end
            ST_CLEAR: begin
                ctrl.clear  = out_free;
                ctrl.out_we = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        unique case (ctrl.coef_sel)
            REG_FEED0: mul_a = feed0_reg;
            REG_FEED1: mul_a = feed1_reg;
            REG_FEED2: mul_a = feed2_reg;
            REG_BACK1: mul_a = back1_reg;
            REG_BACK2: mul_a = back2_reg;
            default:   mul_a = '0;
        endcase
    end

    assign mul_sample = (ctrl.mul_src == MUL_SAMPLE_IN) ? s_sample : x_reg;
    assign mul_b = (ctrl.mul_src == MUL_Y) ? y_reg
                 : {{(STATE_W-SAMPLE_W){mul_sample[SAMPLE_W-1]}}, mul_sample};

    assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    // Products with y carry 32 fraction bits; the shift floors them back to 16.
    assign prod_scaled = ctrl.shift_en ? (prod_full >>> FRAC_W) : prod_full;

    // ---------------- shared saturating adder ----------------
    assign add_a_val = (ctrl.add_a == ADD_A_ACC) ? acc_reg : prod_reg;

    always_comb begin
        unique case (ctrl.add_b)
            ADD_B_Z1:   add_b_val = z1_reg;
            ADD_B_Z2:   add_b_val = z2_reg;
            ADD_B_PROD: add_b_val = prod_reg;
            default:    add_b_val = '0;
        endcase
    end

    assign sum_val = sat_sum(add_a_val, add_b_val, ctrl.add_sub);

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            x_reg <= s_sample;
        end
        if (ctrl.prod_we) begin
            prod_reg <= sat_prod(prod_scaled);
        end
        if (ctrl.y_we) begin
            y_reg <= sum_val;
        end
        if (ctrl.acc_we) begin
            acc_reg <= sum_val;
        end
        if (ctrl.out_we) begin
            filtered_reg <= ctrl.clear ? '0 : sat_out(y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z1_reg <= '0;
            z2_reg <= '0;
        end else begin
            if (ctrl.clear) begin
                z1_reg <= '0;
                z2_reg <= '0;
            end else begin
                if (ctrl.z1_we) begin
                    z1_reg <= sum_val;
                end
                if (ctrl.z2_we) begin
                    z2_reg <= sum_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_we) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // ---------------- assertions ----------------
`ifndef ASSERT_OFF
    // A result appears only out of the last filter step or the clear step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_Z2 || $past(state_reg) == ST_CLEAR))
        else $error("result appeared outside a final step");

    // A clear item leaves both delay registers at zero.
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && out_free) |=> (z1_reg == '0 && z2_reg == '0))
        else $error("delay state not cleared");

    // An accepted filter item starts the sequence at the y step.
    a_filter_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_command == CMD_FILTER) |=> (state_reg == ST_Y))
        else $error("filter item did not start the sequence");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the biquad IIR filter under random traffic, stalls and coefficients.
module tb;
    import biq_pkg::*;

    localparam int COEF_COUNT   = 5;
    localparam int COEF_MAX     = 262143;
    localparam int COEF_MIN     = -262144;
    localparam int COEF_ONE     = 65536;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;

    typedef enum {SET_STABLE, SET_FULL, SET_EXTREME} coef_set_t;
    typedef enum {RX_FREE, RX_COIN, RX_STALLS, RX_SPARSE} rx_mode_t;

    // Tracks the filter state and holds the outputs still owed by the block.
    class biquad_checker;
        longint coef [COEF_COUNT];
        longint delay_one, delay_two;
        logic signed [SAMPLE_W-1:0] expected_filtered [$];
        int errors;

        function new();
            foreach (coef[i]) coef[i] = 0;
            delay_one = 0;
            delay_two = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_filtered.size();
        endfunction

        function longint clamp_to(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Coefficient times y carries 32 fraction bits; drop 16 of them by flooring.
        function longint feedback_term(longint c, longint y);
            return clamp_to((c * y) >>> FRAC_W, STATE_W);
        endfunction

        function void set_coef(logic [2:0] idx, logic [APB_DATA_W-1:0] data);
            if (idx < COEF_COUNT) coef[idx] = longint'($signed(data[COEF_W-1:0]));
        endfunction

        function void predict_output(cmd_t cmd, logic signed [SAMPLE_W-1:0] x);
            longint xv, y;
            if (cmd == CMD_CLEAR) begin
                delay_one = 0;
                delay_two = 0;
                expected_filtered.push_back('0);
                return;
            end
            xv = x;
            y = clamp_to(coef[REG_FEED0] * xv + delay_one, STATE_W);
            delay_one = clamp_to(clamp_to(coef[REG_FEED1] * xv + delay_two, STATE_W)
                                 - feedback_term(coef[REG_BACK1], y), STATE_W);
            delay_two = clamp_to(coef[REG_FEED2] * xv - feedback_term(coef[REG_BACK2], y),
                                 STATE_W);
            expected_filtered.push_back(SAMPLE_W'(clamp_to(y >>> FRAC_W, SAMPLE_W)));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("mismatch: %s", msg);
        endtask

        task check_result(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_filtered.size() == 0) begin
                report($sformatf("unexpected output %0d", got));
                return;
            end
            want = expected_filtered.pop_front();
            if (got !== want) report($sformatf("filtered %0d, want %0d", got, want));
        endtask
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    cmd_t                       s_command = CMD_FILTER;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_filtered;

    biquad_checker sb = new();
    int            burst_left = 0;
    rx_mode_t      rx_mode = RX_FREE;
    int            rx_hold = 0;
    int            rx_cycle = 0;

    biquad_iir_filter dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver switches between stall styles, picking each new one at random.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_mode)
                RX_FREE: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                RX_STALLS: begin
                    m_ready <= ~m_ready;
                    rx_hold <= m_ready ? $urandom_range(5, 30) : $urandom_range(0, 3);
                end
                default: m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_filtered);
    end

    function automatic int rand_between(int lo, int hi);
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return roll[0] ? SAMPLE_MAX : SAMPLE_MIN;
        if (roll < 30) return SAMPLE_W'(rand_between(-256, 255));
        return SAMPLE_W'($urandom);
    endfunction

    function automatic int pick_coef(coef_set_t set, int idx);
        case (set)
            SET_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
            SET_FULL: return rand_between(COEF_MIN, COEF_MAX);
            default: begin
                // Keeps the poles inside the unit circle so the state stays lively.
                if (idx == REG_BACK1) return rand_between(-40000, 40000);
                if (idx == REG_BACK2) return rand_between(-20000, 50000);
                return rand_between(-COEF_ONE, COEF_ONE);
            end
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_coef(idx, data);
        @(posedge aclk);
    endtask

    task automatic program_set(input int a0, input int a1, input int a2,
                               input int b1, input int b2);
        write_reg(REG_FEED0, a0);
        write_reg(REG_FEED1, a1);
        write_reg(REG_FEED2, a2);
        write_reg(REG_BACK1, b1);
        write_reg(REG_BACK2, b2);
    endtask

    task automatic feed_item(input cmd_t cmd, input logic signed [SAMPLE_W-1:0] x);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_sample  <= x;
        do @(posedge aclk); while (!s_ready);
        sb.predict_output(cmd, x);
    endtask

    // Stops sending until every owed output is back and the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        coef_set_t set;
        cmd_t      cmd;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Coefficients still at their reset value of zero.
        feed_item(CMD_FILTER, SAMPLE_MAX);
        feed_item(CMD_CLEAR, SAMPLE_MIN);

        // Unity gain passes the sample straight through.
        settle();
        program_set(COEF_ONE, 0, 0, 0, 0);
        feed_item(CMD_FILTER, SAMPLE_MAX);
        feed_item(CMD_FILTER, SAMPLE_MIN);
        feed_item(CMD_FILTER, -1);
        feed_item(CMD_FILTER, 1);
        feed_item(CMD_FILTER, 0);

        // Largest coefficients drive the state and the output into saturation.
        settle();
        program_set(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        repeat (3) feed_item(CMD_FILTER, SAMPLE_MAX);
        repeat (3) feed_item(CMD_FILTER, SAMPLE_MIN);
        feed_item(CMD_CLEAR, -1);

        settle();
        program_set(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        repeat (2) feed_item(CMD_FILTER, SAMPLE_MAX);
        repeat (2) feed_item(CMD_FILTER, SAMPLE_MIN);
        feed_item(CMD_CLEAR, 16'sh1234);

        // Tiny negative outputs show the floor in the feedback products.
        settle();
        program_set(3, COEF_ONE, 0, -COEF_ONE, 1);
        feed_item(CMD_FILTER, -1);
        feed_item(CMD_FILTER, 1);
        feed_item(CMD_FILTER, SAMPLE_MIN);
        feed_item(CMD_FILTER, -1);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph < 3) set = coef_set_t'(ph);
            else set = coef_set_t'($urandom_range(0, 2));
            for (int i = 0; i < COEF_COUNT; i++) write_reg(3'(i), pick_coef(set, i));
            // Writes past the last coefficient must leave the filter alone.
            if (ph == 0 || $urandom_range(0, 2) == 0)
                write_reg(3'(COEF_COUNT + $urandom_range(0, 2)), $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 149) == 0) settle();
                if ($urandom_range(0, 24) == 0) cmd = CMD_CLEAR;
                else cmd = CMD_FILTER;
                feed_item(cmd, pick_sample());
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
